@@ rtl/core/kcnt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kcnt_pkg
// Shared widths, codes and types for the keyed saturating counter table.
// ----------------------------------------------------------------------------
package kcnt_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_KEY_BITS      = 64;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 64;
    localparam int VALUE_W  = 64;
    localparam int DKEY_W   = 64;

    localparam logic [MODE_W-1:0] MODE_INCR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESTORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

    typedef struct packed {
        logic                wr;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } upd_t;

endpackage

`default_nettype wire

@@ rtl/core/kcnt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kcnt_ram
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module kcnt_ram #(
    parameter int DEPTH  = kcnt_pkg::DEF_TABLE_ENTRIES,
    parameter int WIDTH  = kcnt_pkg::COUNT_W,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/kcnt_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kcnt_update
// Modify step for a found entry: saturating increment, monotonic restore
// or plain read.
// ----------------------------------------------------------------------------
module kcnt_update (
    input  logic [kcnt_pkg::MODE_W-1:0]  mode,
    input  logic [kcnt_pkg::VALUE_W-1:0] value,
    input  logic [kcnt_pkg::COUNT_W-1:0] old_count,
    output kcnt_pkg::upd_t               upd
);

    logic [kcnt_pkg::COUNT_W:0] sum;

    assign sum = {1'b0, old_count} + {1'b0, value};

    always_comb
    begin
        upd.wr     = 1'b0;
        upd.count  = old_count;
        upd.status = kcnt_pkg::ST_OK;
        case (mode)
            kcnt_pkg::MODE_INCR:
            begin
                upd.wr    = 1'b1;
                upd.count = sum[kcnt_pkg::COUNT_W] ? '1 : sum[kcnt_pkg::COUNT_W-1:0];
            end
            kcnt_pkg::MODE_RESTORE:
            begin
                if (value < old_count)
                begin
                    upd.status = kcnt_pkg::ST_STALE;
                end
                else
                begin
                    upd.wr    = 1'b1;
                    upd.count = value;
                end
            end
            default:
            begin
                upd.wr = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/keyed_saturating_counter_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_saturating_counter_table
// Table of saturating 64-bit counters tagged by device key, held in a key
// memory and a count memory, with a sequential key scan.
// ----------------------------------------------------------------------------
// One item is handled at a time. After an item is accepted the key memory is
// scanned one filled slot per clock; on a hit the count is then read, modified
// and written back, and on a miss a write mode stores the key and value in the
// next free slot unless the table is full.
// The next item is taken in the cycle after the result is loaded into the
// output register, even if that result is still stalled.
module keyed_saturating_counter_table #(
    parameter int TABLE_ENTRIES = kcnt_pkg::DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = kcnt_pkg::DEF_KEY_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [kcnt_pkg::MODE_W-1:0]     mode,
    input  logic [kcnt_pkg::DKEY_W-1:0]     device_key,
    input  logic [kcnt_pkg::VALUE_W-1:0]    value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [kcnt_pkg::COUNT_W-1:0]    count,
    output logic [kcnt_pkg::STATUS_W-1:0]   status
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_HIT  = 4'b0100,
        S_MISS = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [FILL_W-1:0]             fill_reg, fill_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [kcnt_pkg::MODE_W-1:0]   mode_reg;
    logic [KEY_BITS-1:0]           key_reg;
    logic [kcnt_pkg::VALUE_W-1:0]  value_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [kcnt_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [kcnt_pkg::STATUS_W-1:0] status_reg, status_next;

    logic                          in_accept;
    logic                          out_free;
    logic                          is_write;
    logic                          table_full;
    logic [IDX_W-1:0]              idx_inc;

    logic                          key_wr_en;
    logic [IDX_W-1:0]              key_rd_addr;
    logic [KEY_BITS-1:0]           key_rd_data;
    logic                          cnt_wr_en;
    logic [IDX_W-1:0]              cnt_wr_addr;
    logic [kcnt_pkg::COUNT_W-1:0]  cnt_wr_data;
    logic [kcnt_pkg::COUNT_W-1:0]  cnt_rd_data;

    kcnt_pkg::upd_t                upd;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign is_write   = (mode_reg == kcnt_pkg::MODE_INCR) ||
                        (mode_reg == kcnt_pkg::MODE_RESTORE);
    assign table_full = (fill_reg == FILL_W'(TABLE_ENTRIES));
    assign idx_inc    = idx_reg + IDX_W'(1);
    assign key_rd_addr = (state_reg == S_IDLE) ? '0 : idx_inc;

    kcnt_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .WIDTH  (KEY_BITS),
        .ADDR_W (IDX_W)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (key_reg),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    kcnt_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .WIDTH  (kcnt_pkg::COUNT_W),
        .ADDR_W (IDX_W)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (idx_reg),
        .rd_data (cnt_rd_data)
    );

    kcnt_update u_update (
        .mode      (mode_reg),
        .value     (value_reg),
        .old_count (cnt_rd_data),
        .upd       (upd)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        count_next     = count_reg;
        status_next    = status_reg;
        key_wr_en      = 1'b0;
        cnt_wr_en      = 1'b0;
        cnt_wr_addr    = idx_reg;
        cnt_wr_data    = upd.count;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next   = '0;
                    state_next = (fill_reg == '0) ? S_MISS : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (key_rd_data == key_reg)
                begin
                    state_next = S_HIT;
                end
                else if ((FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_HIT:
            begin
                if (out_free)
                begin
                    cnt_wr_en      = upd.wr;
                    count_next     = upd.count;
                    status_next    = upd.status;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (out_free)
                begin
                    count_next     = '0;
                    status_next    = kcnt_pkg::ST_OK;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (is_write)
                    begin
                        if (table_full)
                        begin
                            status_next = kcnt_pkg::ST_FULL;
                        end
                        else
                        begin
                            key_wr_en   = 1'b1;
                            cnt_wr_en   = 1'b1;
                            cnt_wr_addr = fill_reg[IDX_W-1:0];
                            cnt_wr_data = value_reg;
                            count_next  = value_reg;
                            fill_next   = fill_reg + FILL_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg  <= mode;
            key_reg   <= device_key[KEY_BITS-1:0];
            value_reg <= value;
        end
        count_reg  <= count_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

@@ bench/keyed_saturating_counter_table_test.sv @@
// ----------------------------------------------------------------------------
// keyed_saturating_counter_table_test
// Self-checking bench for the keyed saturating counter table. A short table of
// directed items fills the table and hits saturation, stale restores and
// dropped keys. Random items with random idling on both sides follow. Each
// result is compared with its listed value or a behavioral copy of the counter table.
// ----------------------------------------------------------------------------
module keyed_saturating_counter_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = kcnt_pkg::DEF_TABLE_ENTRIES;
    localparam int ITEMS_PER_PHASE = 234;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [kcnt_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [kcnt_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [kcnt_pkg::COUNT_W-1:0]  count;
        logic [kcnt_pkg::STATUS_W-1:0] status;
    } tally_t;

    typedef struct {
        logic [kcnt_pkg::MODE_W-1:0]  mode;
        logic [kcnt_pkg::DKEY_W-1:0]  key;
        logic [kcnt_pkg::VALUE_W-1:0] value;
        bit                           typed;
        tally_t                       want;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [kcnt_pkg::MODE_W-1:0]   mode = kcnt_pkg::MODE_READ;
    logic [kcnt_pkg::DKEY_W-1:0]   device_key = '0;
    logic [kcnt_pkg::VALUE_W-1:0]  value = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [kcnt_pkg::COUNT_W-1:0]  count;
    logic [kcnt_pkg::STATUS_W-1:0] status;

    logic [kcnt_pkg::DKEY_W-1:0]   slot_key [TABLE_SLOTS];
    logic [kcnt_pkg::COUNT_W-1:0]  slot_count [TABLE_SLOTS];
    int                            slots_used = 0;

    tally_t                        expected_counts [$];
    stim_row_t                     directed_rows [$];
    int unsigned                   items_sent = 0;
    int unsigned                   results_taken = 0;
    int unsigned                   mismatches = 0;
    int unsigned                   cycle_count = 0;
    int unsigned                   send_idle_pct = 0;
    int unsigned                   recv_stall_pct = 0;

    keyed_saturating_counter_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .device_key (device_key),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .count      (count),
        .status     (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int slot_of(input logic [kcnt_pkg::DKEY_W-1:0] k);
        for (int i = 0; i < slots_used; i++)
        begin
            if (slot_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic tally_t apply_count_op(input logic [kcnt_pkg::MODE_W-1:0] m,
                                              input logic [kcnt_pkg::DKEY_W-1:0] k,
                                              input logic [kcnt_pkg::VALUE_W-1:0] v);
        tally_t                     r;
        int                         s;
        logic [kcnt_pkg::COUNT_W:0] sum;
        r.count = '0;
        r.status = kcnt_pkg::ST_OK;
        s = slot_of(k);
        if (m == kcnt_pkg::MODE_INCR || m == kcnt_pkg::MODE_RESTORE)
        begin
            if (s < 0)
            begin
                if (slots_used < TABLE_SLOTS)
                begin
                    slot_key[slots_used] = k;
                    slot_count[slots_used] = v;
                    slots_used++;
                    r.count = v;
                end
                else
                begin
                    r.status = kcnt_pkg::ST_FULL;
                end
            end
            else if (m == kcnt_pkg::MODE_INCR)
            begin
                sum = {1'b0, slot_count[s]} + {1'b0, v};
                slot_count[s] = sum[kcnt_pkg::COUNT_W] ? COUNT_MAX
                                                       : sum[kcnt_pkg::COUNT_W-1:0];
                r.count = slot_count[s];
            end
            else
            begin
                if (v < slot_count[s])
                    r.status = kcnt_pkg::ST_STALE;
                else
                    slot_count[s] = v;
                r.count = slot_count[s];
            end
        end
        else if (s >= 0)
        begin
            r.count = slot_count[s];
        end
        return r;
    endfunction

    task automatic add_row(input logic [kcnt_pkg::MODE_W-1:0] m,
                           input logic [kcnt_pkg::DKEY_W-1:0] k,
                           input logic [kcnt_pkg::VALUE_W-1:0] v, input bit typed,
                           input logic [kcnt_pkg::COUNT_W-1:0] c,
                           input logic [kcnt_pkg::STATUS_W-1:0] st);
        stim_row_t row;
        row.mode = m;
        row.key = k;
        row.value = v;
        row.typed = typed;
        row.want.count = c;
        row.want.status = st;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic send_item(input logic [kcnt_pkg::MODE_W-1:0] m,
                             input logic [kcnt_pkg::DKEY_W-1:0] k,
                             input logic [kcnt_pkg::VALUE_W-1:0] v, input bit typed,
                             input tally_t want);
        tally_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        device_key <= k;
        value <= v;
        do @(posedge clk); while (in_stall);
        predicted = apply_count_op(m, k, v);
        expected_counts.insert(expected_counts.size(), typed ? want : predicted);
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        tally_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_taken <= results_taken + 1;
            if (expected_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: count %h status %0d", count, status);
            end
            else
            begin
                want = expected_counts.pop_front();
                if (count !== want.count || status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: count %h status %0d, expected count %h status %0d",
                                 count, status, want.count, want.status);
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("keyed_saturating_counter_table_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int                           phase;
        int                           n;
        int                           roll;
        int                           s;
        logic [kcnt_pkg::MODE_W-1:0]  m;
        logic [kcnt_pkg::DKEY_W-1:0]  k;
        logic [kcnt_pkg::VALUE_W-1:0] v;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, saturation and stale restores on the first entries.
        add_row(kcnt_pkg::MODE_READ, 64'h0, COUNT_MAX, 1'b1, 64'h0, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'h0, COUNT_MAX, 1'b1, COUNT_MAX, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'h0, 64'h1, 1'b1, COUNT_MAX, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_RESTORE, 64'h0, 64'h0, 1'b1, COUNT_MAX, kcnt_pkg::ST_STALE);
        add_row(kcnt_pkg::MODE_RESTORE, 64'h0, COUNT_MAX, 1'b1, COUNT_MAX, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_RESTORE, 64'h8000_0000_0000_0001, 64'd100, 1'b1,
                64'd100, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_RESTORE, 64'h8000_0000_0000_0001, 64'd99, 1'b1,
                64'd100, kcnt_pkg::ST_STALE);
        add_row(MODE_SPARE, 64'h8000_0000_0000_0001, 64'h0, 1'b0, '0, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1,
                64'h0, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0,
                '0, kcnt_pkg::ST_OK);
        // Fill the remaining slots.
        add_row(kcnt_pkg::MODE_INCR, 64'h0123_4567_89AB_CDEF, 64'd1, 1'b1,
                64'd1, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_RESTORE, 64'hFEDC_BA98_7654_3210, 64'd2, 1'b1,
                64'd2, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'h5555_5555_5555_5555, 64'd1000, 1'b1,
                64'd1000, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_RESTORE, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0001_0000_0000, 1'b1,
                64'h0000_0001_0000_0000, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'h0000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1,
                64'h7FFF_FFFF_FFFF_FFFF, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_RESTORE, 64'h0000_0001_0000_0000, 64'd5, 1'b1,
                64'd5, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 1'b1,
                64'd0, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_RESTORE, 64'h0000_0000_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b1,
                64'h8000_0000_0000_0000, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'hFFFF_FFFF_0000_0000, 64'd17, 1'b1,
                64'd17, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_RESTORE, 64'h0F0F_0F0F_0F0F_0F0F, 64'd300, 1'b1,
                64'd300, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'hF0F0_F0F0_F0F0_F0F0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1,
                64'hFFFF_FFFF_FFFF_FFF0, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_RESTORE, 64'h1000_0000_0000_0010, 64'd42, 1'b1,
                64'd42, kcnt_pkg::ST_OK);
        add_row(kcnt_pkg::MODE_INCR, 64'h0000_0000_0000_0002, 64'd9, 1'b1,
                64'd9, kcnt_pkg::ST_OK);
        // The table is full now.
        add_row(kcnt_pkg::MODE_INCR, 64'h0000_0000_0000_0003, 64'd7, 1'b1,
                64'h0, kcnt_pkg::ST_FULL);
        add_row(kcnt_pkg::MODE_RESTORE, 64'h0000_0000_0000_0003, 64'd7, 1'b1,
                64'h0, kcnt_pkg::ST_FULL);
        add_row(kcnt_pkg::MODE_READ, 64'h0000_0000_0000_0003, 64'd7, 1'b1,
                64'h0, kcnt_pkg::ST_OK);

        foreach (directed_rows[i])
            send_item(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);

        in_valid <= 1'b0;
        do @(posedge clk); while (results_taken != items_sent);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 87 : 0;
            recv_stall_pct = (phase == 0) ? 87 : (phase == 1) ? 7 : 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(0, 99);
                m = (roll < 35) ? kcnt_pkg::MODE_INCR :
                    (roll < 65) ? kcnt_pkg::MODE_RESTORE :
                    (roll < 92) ? kcnt_pkg::MODE_READ : MODE_SPARE;
                if (slots_used > 0 && $urandom_range(0, 99) < 85)
                    k = slot_key[$urandom_range(0, slots_used - 1)];
                else
                    k = {$urandom, $urandom};
                case ($urandom_range(0, 19))
                    0, 1: v = '0;
                    2: v = COUNT_MAX;
                    3: v = COUNT_MAX - 64'($urandom_range(0, 3));
                    4, 5, 6: v = {$urandom, $urandom};
                    default: v = 64'($urandom_range(0, 5000));
                endcase
                s = slot_of(k);
                if (m == kcnt_pkg::MODE_RESTORE && s >= 0 && $urandom_range(0, 3) == 0)
                    v = slot_count[s] + 64'($urandom_range(0, 2)) - 64'd1;
                send_item(m, k, v, 1'b0, '0);
            end
            in_valid <= 1'b0;
            do @(posedge clk); while (results_taken != items_sent);
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_counts.size() == 0)
            $display("keyed_saturating_counter_table_test OK");
        else
            $display("keyed_saturating_counter_table_test NOT OK");
        $finish;
    end

endmodule
